/* rtl/ratt_pkg.sv */
// Shared types and constants for the range address translation table.
// Used by the controller, the datapath and the top level; no dependencies.

package ratt_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int AddrW = 64;

  typedef enum logic [1:0] {
    ActAdd       = 2'd0,
    ActRemove    = 2'd1,
    ActTranslate = 2'd2,
    ActUnused    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatIgnored = 2'd1,
    StatFull    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmDrain,
    FsmApply,
    FsmReply
  } fsm_state_e;

  typedef struct packed {
    logic [AddrW-1:0] rid;
    logic [AddrW-1:0] old_start;
    logic [AddrW-1:0] old_end;
    logic [AddrW-1:0] new_start;
  } entry_t;

  typedef struct packed {
    logic            load;
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            apply;
    logic            reply;
  } ratt_cmd_t;

endpackage

/* rtl/ratt_ctrl.sv */
// Controller for the range address translation table: sequences the table scan.
// Depends on ratt_pkg; drives the datapath through a ratt_cmd_t command bundle.

module ratt_ctrl
  import ratt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output ratt_cmd_t cmd_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  fsm_state_e      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      FsmIdle: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = FsmScan;
        end
      end
      FsmScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = FsmDrain;
        end
      end
      FsmDrain: state_d = FsmApply;
      FsmApply: state_d = FsmReply;
      FsmReply: state_d = FsmIdle;
      default:  state_d = FsmIdle;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_idx = cnt_q;
    busy_o       = 1'b1;
    case (state_q)
      FsmIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      FsmScan:  cmd_o.rd_en = 1'b1;
      FsmDrain: ;
      FsmApply: cmd_o.apply = 1'b1;
      FsmReply: cmd_o.reply = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

endmodule

/* rtl/ratt_dpath.sv */
// Datapath for the range address translation table: entry memory, valid bits,
// scan evaluation and result registers. Depends on ratt_pkg.

module ratt_dpath
  import ratt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ratt_cmd_t        cmd_i,
  input  logic [1:0]       action_i,
  input  logic [AddrW-1:0] resource_id_i,
  input  logic [AddrW-1:0] old_start_i,
  input  logic [AddrW-1:0] old_size_i,
  input  logic [AddrW-1:0] new_start_i,
  input  logic [AddrW-1:0] lookup_address_i,
  output logic             done_o,
  output logic [AddrW-1:0] mapped_address_o,
  output logic             found_o,
  output logic [AddrW-1:0] matched_id_o,
  output logic [1:0]       status_o
);

  entry_t mem [TableEntries];
  entry_t rd_q;
  logic   rd_vld_q;

  logic [TableEntries-1:0] valid_q;

  action_e          act_q;
  logic [AddrW-1:0] id_q, start_q, end_q, nstart_q, addr_q;

  logic            ev_v_q;
  logic [IdxW-1:0] ev_idx_q;

  logic            hit_q, free_q, have_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [AddrW-1:0] best_start_q, best_id_q, best_nstart_q, diff_q;

  logic             done_q;
  logic [AddrW-1:0] mapped_q, mid_q;
  logic             found_q;
  status_e          status_q;

  logic             add_ok, rem_ok, ev_match, ev_in, ev_better, wr_en;
  logic [IdxW-1:0]  wr_idx;
  entry_t           wr_data;

  assign add_ok = (id_q != '0) && (start_q != '0) && (nstart_q != '0);
  assign rem_ok = (id_q != '0) && (start_q != '0);

  assign ev_match = rd_vld_q && (rd_q.rid == id_q) && (rd_q.old_start == start_q);
  assign ev_in    = rd_vld_q && (rd_q.old_start <= addr_q) && (addr_q < rd_q.old_end);
  assign ev_better = !have_q || (rd_q.old_start > best_start_q) ||
                     ((rd_q.old_start == best_start_q) && (rd_q.rid < best_id_q));

  assign wr_en   = cmd_i.apply && (act_q == ActAdd) && add_ok && (hit_q || free_q);
  assign wr_idx  = hit_q ? hit_idx_q : free_idx_q;
  assign wr_data = '{rid: id_q, old_start: start_q, old_end: end_q, new_start: nstart_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_e'(action_i);
      id_q     <= resource_id_i;
      start_q  <= old_start_i;
      end_q    <= old_start_i + old_size_i;
      nstart_q <= new_start_i;
      addr_q   <= lookup_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      ev_v_q   <= 1'b0;
      ev_idx_q <= '0;
    end else begin
      ev_v_q   <= cmd_i.rd_en;
      ev_idx_q <= cmd_i.rd_idx;
      if (cmd_i.rd_en) begin
        rd_vld_q <= valid_q[cmd_i.rd_idx];
      end
      if (ev_v_q && (act_q == ActRemove) && rem_ok && ev_match) begin
        valid_q[ev_idx_q] <= 1'b0;
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      have_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      have_q <= 1'b0;
    end else if (ev_v_q) begin
      if (ev_match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= ev_idx_q;
      end
      if (!rd_vld_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= ev_idx_q;
      end
      if (ev_in && ev_better) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_v_q && ev_in && ev_better) begin
      best_start_q  <= rd_q.old_start;
      best_id_q     <= rd_q.rid;
      best_nstart_q <= rd_q.new_start;
    end
    if (cmd_i.apply) begin
      diff_q <= addr_q - best_start_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      mapped_q <= '0;
      found_q  <= 1'b0;
      mid_q    <= '0;
      status_q <= StatIgnored;
      case (act_q)
        ActAdd: begin
          if (add_ok) begin
            status_q <= (hit_q || free_q) ? StatDone : StatFull;
          end
        end
        ActRemove: begin
          if (rem_ok) begin
            status_q <= StatDone;
          end
        end
        ActTranslate: begin
          if (addr_q != '0) begin
            status_q <= StatDone;
            found_q  <= have_q;
            mapped_q <= have_q ? (best_nstart_q + diff_q) : addr_q;
            mid_q    <= have_q ? best_id_q : '0;
          end
        end
        default: status_q <= StatIgnored;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.reply;
    end
  end

  assign done_o           = done_q;
  assign mapped_address_o = mapped_q;
  assign found_o          = found_q;
  assign matched_id_o     = mid_q;
  assign status_o         = status_q;

endmodule

/* rtl/range_address_translation_table.sv */
// Top level of the range address translation table.
// Depends on ratt_pkg, ratt_ctrl and ratt_dpath.
//
// A command is transferred at a rising edge where start is high and busy is
// low. The action field selects add range, remove range or translate address;
// the other fields are sampled with it and held internally.
// Every command scans the whole table, reading one entry of the entry memory
// per cycle. A drain state, an apply state (table write or offset subtraction)
// and a reply state follow, and the result is shown in the cycle after the
// reply state. Busy is high in every state from the scan to the reply.
// A new command may be transferred in the cycle in which the previous result
// is shown; while busy is high no new command is taken.
// Each result is marked by done_o, which is high for a single cycle, and the
// receiver cannot hold it off; the result ports keep it until the next reply.
// Reset empties the table at once by clearing every valid bit; no clearing
// pass is needed and the block is ready in the first cycle after reset.

module range_address_translation_table
  import ratt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [AddrW-1:0] resource_id_i,
  input  logic [AddrW-1:0] old_start_i,
  input  logic [AddrW-1:0] old_size_i,
  input  logic [AddrW-1:0] new_start_i,
  input  logic [AddrW-1:0] lookup_address_i,
  output logic             done_o,
  output logic [AddrW-1:0] mapped_address_o,
  output logic             found_o,
  output logic [AddrW-1:0] matched_id_o,
  output logic [1:0]       status_o
);

  ratt_cmd_t cmd;

  ratt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  ratt_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .resource_id_i    (resource_id_i),
    .old_start_i      (old_start_i),
    .old_size_i       (old_size_i),
    .new_start_i      (new_start_i),
    .lookup_address_i (lookup_address_i),
    .done_o           (done_o),
    .mapped_address_o (mapped_address_o),
    .found_o          (found_o),
    .matched_id_o     (matched_id_o),
    .status_o         (status_o)
  );

endmodule
